/* hdl/nrcc_pkg.sv */
package nrcc_pkg;

	// Number of reference colors taken into account (1 to 7).
	localparam int NumClasses = 7;
	// Distance lanes in the datapath; unused lanes are held disabled.
	localparam int LaneCount  = 8;
	localparam int ClassW     = 3;
	localparam int ChanW      = 8;
	localparam int SqW        = 2 * ChanW + 1;
	localparam int DistW      = 9;
	localparam int RegW       = 17;
	localparam int EnableBit  = 16;
	localparam int PairCount  = 9;
	localparam int RemW       = 12;
	localparam int ThrW       = 2 * (DistW + 1);
	localparam int InDataW    = 16;
	localparam int OutDataW   = 16;

	// A disabled lane shows the largest squared distance, so it never wins the minimum.
	localparam logic [SqW-1:0] SqMax = '1;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [SqW-1:0]   sq_t;
	typedef logic [RegW-1:0]  ref_t;

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [DistW-1:0] root;
	} sqrt_t;

	// One step of the digit-by-digit square root: brings in the next two bits of the radicand.
	function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
		logic [RemW-1:0] rem_sh;
		logic [RemW-1:0] trial;
		sqrt_t           nxt;
		rem_sh = {cur.rem[RemW-3:0], pair};
		trial  = {1'b0, cur.root, 2'b01};
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {cur.root[DistW-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {cur.root[DistW-2:0], 1'b0};
		end
		return nxt;
	endfunction

	function automatic chan_t abs_diff(chan_t a, chan_t b);
		return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
	endfunction

endpackage

/* hdl/nearest_reference_color_classifier.sv */
// Channel    | Direction | Handshake                      | Word contents (low bit first)
// -----------+-----------+--------------------------------+----------------------------------
// s_axis     | in        | s_axis_tvalid / s_axis_tready  | tdata: pixel_hue, pixel_saturation
// m_axis     | out       | m_axis_tvalid / m_axis_tready  | tdata: class_index, nearest_distance
//            |           |                                | tuser: class_found
// cfg        | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data (ref_color_k)
//
// One pixel word is taken every cycle while the pipeline is not stalled. Each result
// passes through stages 1 to 9 and is held in the stage 9 output register until taken.
// The rate is set by the nine-stage pipeline, where every stage can load each cycle.
// Each stage holds only while the stage after it is full and blocked, so bubbles are
// squeezed out and a stall at the output loses and repeats nothing.
// Reset clears the reference colors (all classes disabled) and every stage's valid bit.
// Configuration writes are always accepted and take effect on the next cycle.
module nearest_reference_color_classifier (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [nrcc_pkg::InDataW-1:0]        s_axis_tdata,   // pixel_hue, pixel_saturation
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [nrcc_pkg::OutDataW-1:0]       m_axis_tdata,   // class_index, nearest_distance, zero pad
	output logic [0:0]                          m_axis_tuser,   // class_found
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nrcc_pkg::ClassW-1:0]         cfg_index,
	input  logic [nrcc_pkg::RegW-1:0]           cfg_data
);

	localparam int Lanes = nrcc_pkg::LaneCount;
	localparam int Pairs = nrcc_pkg::PairCount;
	localparam int Dw    = nrcc_pkg::DistW;

	// Reference color registers.
	nrcc_pkg::ref_t ref_q [nrcc_pkg::NumClasses];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < nrcc_pkg::NumClasses; k++) begin
				ref_q[k] <= '0;
			end
		end else if (cfg_valid && (32'(cfg_index) < nrcc_pkg::NumClasses)) begin
			ref_q[cfg_index] <= cfg_data;
		end
	end

	// Stage valid bits and load enables. A stage loads when it is empty or its
	// successor is loading this cycle.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ld9;

	assign ld9 = !vld_s9 || m_axis_tready;
	assign ld8 = !vld_s8 || ld9;
	assign ld7 = !vld_s7 || ld8;
	assign ld6 = !vld_s6 || ld7;
	assign ld5 = !vld_s5 || ld6;
	assign ld4 = !vld_s4 || ld5;
	assign ld3 = !vld_s3 || ld4;
	assign ld2 = !vld_s2 || ld3;
	assign ld1 = !vld_s1 || ld2;

	assign s_axis_tready = ld1;
	assign m_axis_tvalid = vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= s_axis_tvalid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
			if (ld7) vld_s7 <= vld_s6;
			if (ld8) vld_s8 <= vld_s7;
			if (ld9) vld_s9 <= vld_s8;
		end
	end

	// Stage 1: per-lane absolute hue and saturation differences.
	nrcc_pkg::chan_t pix_hue, pix_sat;
	nrcc_pkg::chan_t dh_c [Lanes];
	nrcc_pkg::chan_t ds_c [Lanes];
	logic [Lanes-1:0] mask_c;

	assign pix_hue = s_axis_tdata[nrcc_pkg::ChanW-1:0];
	assign pix_sat = s_axis_tdata[2*nrcc_pkg::ChanW-1:nrcc_pkg::ChanW];

	always_comb begin
		mask_c = '0;
		for (int k = 0; k < Lanes; k++) begin
			dh_c[k] = '0;
			ds_c[k] = '0;
		end
		for (int k = 0; k < nrcc_pkg::NumClasses; k++) begin
			mask_c[k] = ref_q[k][nrcc_pkg::EnableBit];
			dh_c[k]   = nrcc_pkg::abs_diff(pix_hue, ref_q[k][2*nrcc_pkg::ChanW-1:nrcc_pkg::ChanW]);
			ds_c[k]   = nrcc_pkg::abs_diff(pix_sat, ref_q[k][nrcc_pkg::ChanW-1:0]);
		end
	end

	nrcc_pkg::chan_t  dh_s1 [Lanes];
	nrcc_pkg::chan_t  ds_s1 [Lanes];
	logic [Lanes-1:0] mask_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			dh_s1   <= dh_c;
			ds_s1   <= ds_c;
			mask_s1 <= mask_c;
		end
	end

	// Stage 2: squared Euclidean distance per lane; disabled lanes read as the maximum.
	nrcc_pkg::sq_t    sq_s2 [Lanes];
	logic [Lanes-1:0] mask_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			for (int k = 0; k < Lanes; k++) begin
				if (mask_s1[k]) begin
					sq_s2[k] <= nrcc_pkg::SqW'(16'(dh_s1[k]) * 16'(dh_s1[k]))
						+ nrcc_pkg::SqW'(16'(ds_s1[k]) * 16'(ds_s1[k]));
				end else begin
					sq_s2[k] <= nrcc_pkg::SqMax;
				end
			end
			mask_s2 <= mask_s1;
		end
	end

	// Stage 3: first level of the minimum tree, lanes taken in pairs.
	nrcc_pkg::sq_t    pmin_s3 [Lanes/2];
	nrcc_pkg::sq_t    sq_s3   [Lanes];
	logic [Lanes-1:0] mask_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			for (int j = 0; j < Lanes/2; j++) begin
				pmin_s3[j] <= (sq_s2[2*j+1] < sq_s2[2*j]) ? sq_s2[2*j+1] : sq_s2[2*j];
			end
			sq_s3   <= sq_s2;
			mask_s3 <= mask_s2;
		end
	end

	// Stage 4: remaining two levels of the tree give the smallest squared distance.
	nrcc_pkg::sq_t    qmin_a, qmin_b;
	nrcc_pkg::sq_t    min_s4;
	nrcc_pkg::sq_t    sq_s4 [Lanes];
	logic [Lanes-1:0] mask_s4;

	assign qmin_a = (pmin_s3[1] < pmin_s3[0]) ? pmin_s3[1] : pmin_s3[0];
	assign qmin_b = (pmin_s3[3] < pmin_s3[2]) ? pmin_s3[3] : pmin_s3[2];

	always_ff @(posedge clk) begin
		if (ld4) begin
			min_s4  <= (qmin_b < qmin_a) ? qmin_b : qmin_a;
			sq_s4   <= sq_s3;
			mask_s4 <= mask_s3;
		end
	end

	// Stages 5 to 7: integer square root of the minimum, three result bits per stage.
	// The radicand is widened by one bit so it splits into whole bit pairs.
	logic [2*Pairs-1:0] rad_s4;
	assign rad_s4 = (2*Pairs)'(min_s4);

	nrcc_pkg::sqrt_t  rt_c5, rt_c6, rt_c7;
	nrcc_pkg::sqrt_t  rt_s5, rt_s6, rt_s7;
	logic [2*Pairs-1:0] rad_s5, rad_s6;
	nrcc_pkg::sq_t    sq_s5 [Lanes];
	nrcc_pkg::sq_t    sq_s6 [Lanes];
	nrcc_pkg::sq_t    sq_s7 [Lanes];
	logic [Lanes-1:0] mask_s5, mask_s6, mask_s7;

	always_comb begin
		rt_c5 = '0;
		for (int p = 0; p < 3; p++) begin
			rt_c5 = nrcc_pkg::sqrt_step(rt_c5, rad_s4[2*(Pairs-1-p) +: 2]);
		end
	end

	always_comb begin
		rt_c6 = rt_s5;
		for (int p = 3; p < 6; p++) begin
			rt_c6 = nrcc_pkg::sqrt_step(rt_c6, rad_s5[2*(Pairs-1-p) +: 2]);
		end
	end

	always_comb begin
		rt_c7 = rt_s6;
		for (int p = 6; p < Pairs; p++) begin
			rt_c7 = nrcc_pkg::sqrt_step(rt_c7, rad_s6[2*(Pairs-1-p) +: 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld5) begin
			rt_s5   <= rt_c5;
			rad_s5  <= rad_s4;
			sq_s5   <= sq_s4;
			mask_s5 <= mask_s4;
		end
		if (ld6) begin
			rt_s6   <= rt_c6;
			rad_s6  <= rad_s5;
			sq_s6   <= sq_s5;
			mask_s6 <= mask_s5;
		end
		if (ld7) begin
			rt_s7   <= rt_c7;
			sq_s7   <= sq_s6;
			mask_s7 <= mask_s6;
		end
	end

	// Stage 8: a lane's floored distance equals the minimum's floor f exactly when
	// its squared distance is below (f+1)^2, so that bound is formed here.
	logic [Dw:0]              root_p1;
	logic [Dw-1:0]            root_s8;
	logic [nrcc_pkg::ThrW-1:0] thr_s8;
	nrcc_pkg::sq_t            sq_s8 [Lanes];
	logic [Lanes-1:0]         mask_s8;

	assign root_p1 = (Dw+1)'(rt_s7.root) + (Dw+1)'(1);

	always_ff @(posedge clk) begin
		if (ld8) begin
			thr_s8  <= nrcc_pkg::ThrW'(root_p1) * nrcc_pkg::ThrW'(root_p1);
			root_s8 <= rt_s7.root;
			sq_s8   <= sq_s7;
			mask_s8 <= mask_s7;
		end
	end

	// Stage 9 (output register): the earliest enabled lane that shares the minimum
	// floored distance wins. With no class enabled every field reads zero.
	logic [nrcc_pkg::ClassW-1:0] idx_c;
	logic                        found_c;
	logic [nrcc_pkg::ClassW-1:0] idx_s9;
	logic                        found_s9;
	logic [Dw-1:0]               dist_s9;

	always_comb begin
		idx_c = '0;
		for (int k = Lanes - 1; k >= 0; k--) begin
			if (mask_s8[k] && (nrcc_pkg::ThrW'(sq_s8[k]) < thr_s8)) begin
				idx_c = nrcc_pkg::ClassW'(k);
			end
		end
		found_c = |mask_s8;
	end

	always_ff @(posedge clk) begin
		if (ld9) begin
			idx_s9   <= idx_c;
			found_s9 <= found_c;
			dist_s9  <= found_c ? root_s8 : '0;
		end
	end

	assign m_axis_tdata = nrcc_pkg::OutDataW'({dist_s9, idx_s9});
	assign m_axis_tuser = found_s9;

endmodule

/* hdl/nrcc_checker.sv */
module nrcc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [nrcc_pkg::InDataW-1:0]  s_axis_tdata,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [nrcc_pkg::OutDataW-1:0] m_axis_tdata,
	input logic [0:0]                    m_axis_tuser,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [nrcc_pkg::ClassW-1:0]   cfg_index,
	input logic [nrcc_pkg::RegW-1:0]     cfg_data
);

	// A stalled result word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// With no class enabled, index and distance both read zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("nonzero result without a found class");

	// The chosen class is one that exists, and the distance stays within the plane.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata[nrcc_pkg::ClassW-1:0]) < nrcc_pkg::NumClasses)
			&& (m_axis_tdata[nrcc_pkg::ClassW +: nrcc_pkg::DistW] <= 9'd360))
		else $error("result field out of range");

	// Configuration words are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration word refused");

endmodule

bind nearest_reference_color_classifier nrcc_checker u_nrcc_checker (.*);
